[hw/rtl/brb_pkg.sv]
`default_nettype none
package brb_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int DATA_W        = 32;
  localparam int STAT_W        = 10;
  localparam int CNT_W         = 3;
  localparam int BYTE_W        = 8;

  // function codes
  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_COMMIT = 2'd2;
  localparam logic [1:0] FN_REWIND = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 3'd4;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]        func;
    logic [DATA_W-1:0] wdata;
    logic [CNT_W-1:0]  count;
    logic              big_endian;
    logic              cnt_legal;  // count in 0..4
    logic              cnt_zero;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/brb_ram.sv]
`default_nettype none
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[hw/rtl/brb_front.sv]
`default_nettype none
module brb_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [1:0]                  func,
  input  wire logic [brb_pkg::DATA_W-1:0]  wdata,
  input  wire logic [brb_pkg::CNT_W-1:0]   count,
  input  wire logic                        big_endian,
  output logic                             q_valid,
  output brb_pkg::cmd_t                    q_cmd,
  input  wire logic                        q_pop
);
  import brb_pkg::*;

  // two-entry queue toward the back end
  cmd_t       entry [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] fill;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.func       = func;
    cmd_in.wdata      = wdata;
    cmd_in.count      = count;
    cmd_in.big_endian = big_endian;
    cmd_in.cnt_legal  = (count <= CNT_MAX);
    cmd_in.cnt_zero   = (count == '0);
  end

  assign req_ready = (fill != 2'd2);
  assign push      = req_valid && req_ready;
  assign pop       = q_pop && (fill != 2'd0);
  assign q_valid   = (fill != 2'd0);
  assign q_cmd     = entry[rd_sel];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_sel] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/brb_back.sv]
`default_nettype none
module brb_back #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire brb_pkg::cmd_t               q_cmd,
  output logic                             q_pop,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output logic                             ok,
  output logic [brb_pkg::DATA_W-1:0]       rdata,
  output logic [brb_pkg::STAT_W-1:0]       free_space,
  output logic [brb_pkg::STAT_W-1:0]       readable
);
  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = (AW > STAT_W) ? AW : STAT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state;
  logic [AW-1:0]     write_ptr;
  logic [AW-1:0]     read_ptr;
  logic [AW-1:0]     start_ptr;
  logic [CNT_W-1:0]  rem;
  logic [DATA_W-1:0] wsh;
  logic [DATA_W-1:0] acc;
  logic [1:0]        idx;
  logic              big;
  logic              pend;
  logic              ok_r;

  logic [AW:0]       free_diff;
  logic [AW:0]       rdbl_diff;
  logic [AW-1:0]     free_cur;
  logic [AW-1:0]     rdbl_cur;
  logic [SW-1:0]     free_wide;
  logic [SW-1:0]     rdbl_wide;
  logic              wr_ok;
  logic              rd_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // occupancy from the current pointers, wrapped mod DEPTH
  always_comb begin
    free_diff = {1'b0, start_ptr} - {1'b0, write_ptr} - (AW+1)'(1);
    if (free_diff[AW]) begin
      free_diff = free_diff + (AW+1)'(DEPTH);
    end
    rdbl_diff = {1'b0, write_ptr} - {1'b0, read_ptr};
    if (rdbl_diff[AW]) begin
      rdbl_diff = rdbl_diff + (AW+1)'(DEPTH);
    end
    free_cur  = free_diff[AW-1:0];
    rdbl_cur  = rdbl_diff[AW-1:0];
    free_wide = SW'(free_cur);
    rdbl_wide = SW'(rdbl_cur);
  end

  assign wr_ok = q_cmd.cnt_legal && (AW'(q_cmd.count) <= free_cur);
  assign rd_ok = q_cmd.cnt_legal && (AW'(q_cmd.count) <= rdbl_cur);

  assign q_pop    = (state == S_IDLE);
  assign ram_we   = (state == S_WR);
  assign ram_addr = (state == S_WR) ? write_ptr : read_ptr;

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wsh[BYTE_W-1:0]),
    .rdata (ram_rdata)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        wsh <= q_cmd.wdata;
        acc <= '0;
        idx <= 2'd0;
        big <= q_cmd.big_endian;
        rem <= q_cmd.count;
      end
      S_WR: begin
        wsh <= wsh >> BYTE_W;
        rem <= rem - CNT_W'(1);
      end
      S_RD, S_RDW: begin
        if (state == S_RD) begin
          rem <= rem - CNT_W'(1);
        end
        if (pend) begin
          if (big) begin
            acc <= {acc[DATA_W-BYTE_W-1:0], ram_rdata};
          end else begin
            acc <= acc | (DATA_W'(ram_rdata) << {idx, 3'b000});
          end
          idx <= idx + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      write_ptr <= '0;
      read_ptr  <= '0;
      start_ptr <= '0;
      pend      <= 1'b0;
      ok_r      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      pend <= (state == S_RD);
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_cmd.func)
              FN_WRITE: begin
                ok_r  <= wr_ok;
                state <= (wr_ok && !q_cmd.cnt_zero) ? S_WR : S_FIN;
              end
              FN_READ: begin
                ok_r  <= rd_ok;
                state <= (rd_ok && !q_cmd.cnt_zero) ? S_RD : S_FIN;
              end
              FN_COMMIT: begin
                ok_r      <= 1'b1;
                start_ptr <= read_ptr;
                state     <= S_FIN;
              end
              FN_REWIND: begin
                ok_r     <= 1'b1;
                read_ptr <= start_ptr;
                state    <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_WR: begin
          write_ptr <= ring_next(write_ptr);
          if (rem == CNT_W'(1)) begin
            state <= S_FIN;
          end
        end
        S_RD: begin
          read_ptr <= ring_next(read_ptr);
          if (rem == CNT_W'(1)) begin
            state <= S_RDW;
          end
        end
        S_RDW: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register; pointers are already updated when in S_FIN
  always_ff @(posedge clk) begin
    if ((state == S_FIN) && (!rsp_valid || rsp_ready)) begin
      ok         <= ok_r;
      rdata      <= acc;
      free_space <= free_wide[STAT_W-1:0];
      readable   <= rdbl_wide[STAT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/byte_ring_buffer_with_read_rollback.sv]
// Writes and reads move one byte per cycle through the single-port byte RAM;
// commit, rewind, refused or zero-count words move no bytes. The back end takes
// a new word only after the last word's result is loaded into its result
// register. Reset clears pointers, queue and result valid; RAM stays undefined
// until written.
`default_nettype none
module byte_ring_buffer_with_read_rollback #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [1:0]                  func,
  input  wire logic [brb_pkg::DATA_W-1:0]  wdata,
  input  wire logic [brb_pkg::CNT_W-1:0]   count,
  input  wire logic                        big_endian,
  // response channel
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output logic                             ok,
  output logic [brb_pkg::DATA_W-1:0]       rdata,
  output logic [brb_pkg::STAT_W-1:0]       free_space,
  output logic [brb_pkg::STAT_W-1:0]       readable
);
  import brb_pkg::*;

  // front -> back word queue
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Front: takes request words, flags count legality, buffers two deep so
  // the request side keeps moving while the back end works on a word.
  brb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .func       (func),
    .wdata      (wdata),
    .count      (count),
    .big_endian (big_endian),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop)
  );

  // Back: owns write/read/start pointers and the byte RAM, moves one byte a
  // cycle, and holds the finished word in its result register until taken.
  brb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .ok         (ok),
    .rdata      (rdata),
    .free_space (free_space),
    .readable   (readable)
  );

endmodule
`default_nettype wire
